// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on clk_i, off while rst_ni is low.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked on clk_i at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/irhd_pkg.sv
// Types, constants and helpers of the IR decoder with mute hold detection.
package irhd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Symbol count saturates here.
  localparam logic [7:0] MaxSymbols = 8'd128;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBitThreshold   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinFrameSyms   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgReleaseTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHoldThreshold  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCodeUp         = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCodeDown       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCodeMute       = 3'd6;

  // Item ops
  localparam logic OpSymbol = 1'b0;
  localparam logic OpTick   = 1'b1;

  // Result kinds
  localparam logic KindFrame   = 1'b0;
  localparam logic KindRelease = 1'b1;

  // Key codes
  localparam logic [2:0] KeyUp      = 3'd0;
  localparam logic [2:0] KeyDown    = 3'd1;
  localparam logic [2:0] KeyMute    = 3'd2;
  localparam logic [2:0] KeyUnknown = 3'd3;
  localparam logic [2:0] KeyShort   = 3'd4;

  typedef struct packed {
    logic        op;
    logic [14:0] mark_duration;
    logic        last_symbol;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  key;
    logic [31:0] code;
    logic [7:0]  frame_symbols;
    logic [15:0] held_count;
    logic        trigger;
  } result_t;

  typedef struct packed {
    logic [14:0] bit_threshold;
    logic [7:0]  min_frame_symbols;
    logic [15:0] release_timeout;
    logic [15:0] hold_threshold;
    logic [31:0] code_up;
    logic [31:0] code_down;
    logic [31:0] code_mute;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    bit_threshold:     15'd1500,
    min_frame_symbols: 8'd34,
    release_timeout:   16'd1000,
    hold_threshold:    16'd30,
    code_up:           32'hFD02FB04,
    code_down:         32'hFC03FB04,
    code_mute:         32'hF609FB04
  };

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    sat16_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// File: hw/rtl/irhd_if.sv
// Handshake interfaces: symbol/tick input, result output, config write.
interface irhd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [14:0] mark_duration;
  logic        last_symbol;

  modport source (output valid, op, mark_duration, last_symbol, input ready);
  modport sink   (input valid, op, mark_duration, last_symbol, output ready);
endinterface

interface irhd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  key;
  logic [31:0] code;
  logic [7:0]  frame_symbols;
  logic [15:0] held_count;
  logic        trigger;

  modport source (output valid, kind, key, code, frame_symbols, held_count, trigger,
                  input ready);
  modport sink   (input valid, kind, key, code, frame_symbols, held_count, trigger,
                  output ready);
endinterface

interface irhd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/irhd_cfg_regs.sv
// Configuration register file of the IR decoder.
module irhd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [irhd_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [irhd_pkg::CfgDataW-1:0]  wr_data_i,
  output irhd_pkg::cfg_t                 cfg_o
);

  irhd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        irhd_pkg::CfgBitThreshold:   cfg_d.bit_threshold     = wr_data_i[14:0];
        irhd_pkg::CfgMinFrameSyms:   cfg_d.min_frame_symbols = wr_data_i[7:0];
        irhd_pkg::CfgReleaseTimeout: cfg_d.release_timeout   = wr_data_i[15:0];
        irhd_pkg::CfgHoldThreshold:  cfg_d.hold_threshold    = wr_data_i[15:0];
        irhd_pkg::CfgCodeUp:         cfg_d.code_up           = wr_data_i;
        irhd_pkg::CfgCodeDown:       cfg_d.code_down         = wr_data_i;
        irhd_pkg::CfgCodeMute:       cfg_d.code_mute         = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= irhd_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/irhd_core.sv
// Frame slicer, key classifier and mute hold tracker.
module irhd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irhd_pkg::cfg_t    cfg_i,
  input  irhd_pkg::item_t   item_i,
  input  logic              commit_i,   // item leaves the input register this cycle
  output logic              has_res_o,
  output irhd_pkg::result_t res_o
);

  logic [7:0]  sym_idx_q, sym_idx_d;
  logic [31:0] shift_q, shift_d;
  logic        hold_act_q, hold_act_d;
  logic [15:0] hold_cnt_q, hold_cnt_d;
  logic [15:0] silence_q, silence_d;

  logic        bit_hit;
  logic [4:0]  bit_pos;
  logic [31:0] shift_new;
  logic [7:0]  idx_new;
  logic        is_short;

  assign bit_pos   = sym_idx_q[4:0] - 5'd1;
  assign bit_hit   = (sym_idx_q >= 8'd1) && (sym_idx_q <= 8'd32)
                     && (item_i.mark_duration > cfg_i.bit_threshold);
  assign shift_new = shift_q | (bit_hit ? (32'd1 << bit_pos) : 32'd0);
  assign idx_new   = (sym_idx_q < irhd_pkg::MaxSymbols) ? sym_idx_q + 8'd1 : sym_idx_q;
  assign is_short  = idx_new < cfg_i.min_frame_symbols;

  always_comb begin
    sym_idx_d  = sym_idx_q;
    shift_d    = shift_q;
    hold_act_d = hold_act_q;
    hold_cnt_d = hold_cnt_q;
    silence_d  = silence_q;
    has_res_o  = 1'b0;
    res_o      = '0;

    if (item_i.op == irhd_pkg::OpTick) begin
      if (hold_act_q) begin
        if (silence_q >= cfg_i.release_timeout) begin
          has_res_o        = 1'b1;
          res_o.kind       = irhd_pkg::KindRelease;
          res_o.key        = irhd_pkg::KeyMute;
          res_o.held_count = hold_cnt_q;
          res_o.trigger    = hold_cnt_q >= cfg_i.hold_threshold;
          hold_act_d       = 1'b0;
          hold_cnt_d       = '0;
          silence_d        = '0;
        end else begin
          silence_d = irhd_pkg::sat16_inc(silence_q);
        end
      end
    end else if (!item_i.last_symbol) begin
      sym_idx_d = idx_new;
      shift_d   = shift_new;
    end else begin
      // frame end: report and restart collection
      sym_idx_d           = '0;
      shift_d             = '0;
      has_res_o           = 1'b1;
      res_o.kind          = irhd_pkg::KindFrame;
      res_o.frame_symbols = idx_new;
      if (is_short) begin
        res_o.key = irhd_pkg::KeyShort;
        if (hold_act_q) begin
          hold_cnt_d = irhd_pkg::sat16_inc(hold_cnt_q);
          silence_d  = '0;
        end
      end else begin
        res_o.code = shift_new;
        if (shift_new == cfg_i.code_up) begin
          res_o.key = irhd_pkg::KeyUp;
        end else if (shift_new == cfg_i.code_down) begin
          res_o.key = irhd_pkg::KeyDown;
        end else if (shift_new == cfg_i.code_mute) begin
          res_o.key  = irhd_pkg::KeyMute;
          hold_act_d = 1'b1;
          hold_cnt_d = hold_act_q ? irhd_pkg::sat16_inc(hold_cnt_q) : 16'd1;
          silence_d  = '0;
        end else begin
          res_o.key = irhd_pkg::KeyUnknown;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_idx_q  <= '0;
      shift_q    <= '0;
      hold_act_q <= 1'b0;
      hold_cnt_q <= '0;
      silence_q  <= '0;
    end else if (commit_i) begin
      sym_idx_q  <= sym_idx_d;
      shift_q    <= shift_d;
      hold_act_q <= hold_act_d;
      hold_cnt_q <= hold_cnt_d;
      silence_q  <= silence_d;
    end
  end

endmodule

// File: hw/rtl/ir_remote_decoder_hold_detect.sv
// Top level of the IR remote decoder with mute hold detection.
//
// in_i carries items: op 0 is one IR symbol (mark_duration, last_symbol),
// op 1 is one time tick. Symbols 1..32 of a frame are sliced into a 32-bit
// code; the last symbol of a frame yields one frame result on out_o. Ticks
// age an active mute hold and yield a release result once the silence
// reaches release_timeout. Other items yield no result.
// cfg_i writes the seven configuration registers by index; it is always
// ready and should only be used while no item is in flight.
// An item is held in the input register while the core works on it; its
// result then waits in the output register for out_o.
// Throughput: one item per cycle unless out_o stalls; the state update is a
// single compare, shift and counter step between the input and output registers.
// When out_o stalls, the waiting result holds steady and one more item
// may sit in the input register; items without a result keep flowing.
// Reset clears the frame and hold state, empties both registers and loads
// the register defaults.
module ir_remote_decoder_hold_detect (
  input  logic        clk_i,
  input  logic        rst_ni,
  irhd_in_if.sink     in_i,
  irhd_out_if.source  out_o,
  irhd_cfg_if.sink    cfg_i
);

  irhd_pkg::cfg_t    cfg;
  irhd_pkg::item_t   s1_item_q;
  logic              s1_valid_q;
  irhd_pkg::result_t out_q, core_res;
  logic              out_valid_q;
  logic              core_has;
  logic              out_free;
  logic              advance;
  logic              in_xfer;

  assign cfg_i.ready = 1'b1;

  irhd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  irhd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (s1_item_q),
    .commit_i  (advance),
    .has_res_o (core_has),
    .res_o     (core_res)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = s1_valid_q && (!core_has || out_free);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_xfer     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer || (s1_valid_q && !advance);
      if (advance && core_has) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.op            <= in_i.op;
      s1_item_q.mark_duration <= in_i.mark_duration;
      s1_item_q.last_symbol   <= in_i.last_symbol;
    end
    if (advance && core_has) begin
      out_q <= core_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.key           = out_q.key;
  assign out_o.code          = out_q.code;
  assign out_o.frame_symbols = out_q.frame_symbols;
  assign out_o.held_count    = out_q.held_count;
  assign out_o.trigger       = out_q.trigger;

endmodule

// File: hw/rtl/irhd_checker.sv
// Port-level checker for the IR decoder, bound to the top level.
`include "assert_macros.svh"

module irhd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [2:0]  out_key_i,
  input logic [31:0] out_code_i,
  input logic [7:0]  out_frame_symbols_i,
  input logic [15:0] out_held_count_i,
  input logic        out_trigger_i
);

  logic [60:0] out_payload;
  logic        rel_ok;
  logic        frm_ok;

  assign out_payload = {out_kind_i, out_key_i, out_code_i, out_frame_symbols_i,
                        out_held_count_i, out_trigger_i};
  assign rel_ok = (out_key_i == irhd_pkg::KeyMute) && (out_code_i == 32'd0)
                  && (out_frame_symbols_i == 8'd0);
  assign frm_ok = (out_held_count_i == 16'd0) && !out_trigger_i;

  // stalled result must not change
  `ASSERT_RST(out_hold_a, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload))

  // a new result must be preceded by an item transfer on in_i
  `ASSERT_RST(out_rise_a, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))

  `ASSERT_RST(release_fields_a, out_valid_i && out_kind_i == irhd_pkg::KindRelease |-> rel_ok)

  `ASSERT_RST(frame_fields_a, out_valid_i && out_kind_i == irhd_pkg::KindFrame |-> frm_ok)

  `ASSERT_ALWAYS(reset_empty_a, !rst_ni |-> !out_valid_i)

endmodule

bind ir_remote_decoder_hold_detect irhd_checker u_irhd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_kind_i          (out_o.kind),
  .out_key_i           (out_o.key),
  .out_code_i          (out_o.code),
  .out_frame_symbols_i (out_o.frame_symbols),
  .out_held_count_i    (out_o.held_count),
  .out_trigger_i       (out_o.trigger)
);
